FILE: rtl/psu_pkg.sv
// Shared types, register indexes and filter codes of the scanline unfilter unit.
`default_nettype none
package psu_pkg;

   // Default line store depth in bytes.
   localparam int DEF_MAX_ROW_BYTES = 8192;

   // Register widths.
   localparam int RB_W       = 14;
   localparam int BPP_W      = 3;
   localparam int RC_W       = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BPP       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd2;

   // Filter types.
   localparam logic [2:0] FILT_NONE  = 3'd0;
   localparam logic [2:0] FILT_SUB   = 3'd1;
   localparam logic [2:0] FILT_UP    = 3'd2;
   localparam logic [2:0] FILT_AVG   = 3'd3;
   localparam logic [2:0] FILT_PAETH = 3'd4;

   // What an item in the reconstruction stage asks for.
   localparam logic [1:0] TAG_CLEAR = 2'd0;  // valid filter byte: clear neighbours
   localparam logic [1:0] TAG_BAD   = 2'd1;  // bad filter byte: error result
   localparam logic [1:0] TAG_DATA  = 2'd2;  // data byte: rebuild and emit

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [2:0] filt;
      logic       first;
      logic       row_end;
      logic       image_end;
   } psu_tag_type;

endpackage
`default_nettype wire

FILE: rtl/psu_line_store.sv
// Line store: one-write, one-read synchronous memory holding the previous row.
`default_nettype none
module psu_line_store #(
   parameter int DEPTH  = psu_pkg::DEF_MAX_ROW_BYTES,
   parameter int ADDR_W = $clog2(psu_pkg::DEF_MAX_ROW_BYTES)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/psu_ctrl.sv
// Row and image framing: tracks column, row and filter state for each accepted item.
`default_nettype none
module psu_ctrl #(
   parameter int MAX_ROW_BYTES = psu_pkg::DEF_MAX_ROW_BYTES,
   parameter int COL_W         = $clog2(psu_pkg::DEF_MAX_ROW_BYTES)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [7:0]                 data_byte,
   input  wire logic [psu_pkg::RB_W-1:0]   row_bytes,
   input  wire logic [psu_pkg::RC_W-1:0]   row_count,
   output logic                            tag_valid,
   output psu_pkg::psu_tag_type            tag,
   output logic                            rd_en,
   output logic      [COL_W-1:0]           col_addr
);
   import psu_pkg::*;

   localparam int CMP_W = (RB_W > COL_W + 1) ? RB_W : COL_W + 1;

   logic [COL_W-1:0] col_ff, col_in;
   logic [RC_W-1:0]  row_ff, row_in;
   logic [2:0]       filt_ff, filt_in;
   logic             await_ff, await_in;
   logic             first_ff, first_in;
   logic             disc_ff, disc_in;

   logic [CMP_W-1:0] eff_rb;
   logic [CMP_W-1:0] col_nxt;
   logic [RC_W:0]    eff_rows;
   logic [RC_W:0]    row_nxt;
   logic             row_done;
   logic             image_done;
   logic             bad_code;

   // Effective lengths after clamping.
   always_comb begin
      if (row_bytes == '0) begin
         eff_rb = CMP_W'(1);
      end else if (CMP_W'(row_bytes) > CMP_W'(MAX_ROW_BYTES)) begin
         eff_rb = CMP_W'(MAX_ROW_BYTES);
      end else begin
         eff_rb = CMP_W'(row_bytes);
      end
      eff_rows = (row_count == '0) ? (RC_W+1)'(1) : {1'b0, row_count};
   end

   assign col_nxt    = CMP_W'(col_ff) + CMP_W'(1);
   assign row_nxt    = {1'b0, row_ff} + (RC_W+1)'(1);
   assign row_done   = col_nxt >= eff_rb;
   assign image_done = row_done && (row_nxt >= eff_rows);
   assign bad_code   = data_byte > {5'b0, FILT_PAETH};

   // Tag for the reconstruction stage; discarded items produce none.
   always_comb begin
      tag.data      = data_byte;
      tag.filt      = filt_ff;
      tag.first     = first_ff;
      tag.row_end   = row_done;
      tag.image_end = image_done;
      if (await_ff) begin
         tag.kind  = bad_code ? TAG_BAD : TAG_CLEAR;
         tag_valid = !disc_ff;
         rd_en     = 1'b0;
      end else begin
         tag.kind  = TAG_DATA;
         tag_valid = !disc_ff;
         rd_en     = accept && !disc_ff;
      end
   end

   assign col_addr = col_ff;

   // Next framing state.
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      filt_in  = filt_ff;
      await_in = await_ff;
      first_in = first_ff;
      disc_in  = disc_ff;
      if (await_ff) begin
         await_in = 1'b0;
         col_in   = '0;
         if (!disc_ff) begin
            if (bad_code) begin
               disc_in = 1'b1;
            end else begin
               filt_in = data_byte[2:0];
            end
         end
      end else begin
         col_in = col_nxt[COL_W-1:0];
         if (row_done) begin
            col_in   = '0;
            await_in = 1'b1;
            first_in = 1'b0;
            row_in   = row_nxt[RC_W-1:0];
         end
         if (image_done) begin
            row_in   = '0;
            first_in = 1'b1;
            if (disc_ff) begin
               filt_in = FILT_NONE;
               disc_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         filt_ff  <= FILT_NONE;
         await_ff <= 1'b1;
         first_ff <= 1'b1;
         disc_ff  <= 1'b0;
      end else if (accept) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         filt_ff  <= filt_in;
         await_ff <= await_in;
         first_ff <= first_in;
         disc_ff  <= disc_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/psu_recon.sv
// Reconstruction stage: predictor, neighbour history, line store write-back and result register.
`default_nettype none
module psu_recon #(
   parameter int ADDR_W = $clog2(psu_pkg::DEF_MAX_ROW_BYTES)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load,
   input  wire psu_pkg::psu_tag_type      tag,
   input  wire logic [ADDR_W-1:0]         addr,
   input  wire logic [7:0]                rd_data,
   input  wire logic [psu_pkg::BPP_W-1:0] bytes_per_pixel,
   input  wire logic                      rsp_stall,
   output logic                           busy,
   output logic                           wr_en,
   output logic      [ADDR_W-1:0]         wr_addr,
   output logic      [7:0]                wr_data,
   output logic                           rsp_valid,
   output logic      [7:0]                rsp_pixel_byte,
   output logic                           rsp_row_end,
   output logic                           rsp_image_end,
   output logic                           rsp_bad_filter
);
   import psu_pkg::*;

   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic signed [9:0] p, da, db, dc;
      p  = $signed({2'b0, a}) + $signed({2'b0, b}) - $signed({2'b0, c});
      da = p - $signed({2'b0, a});
      db = p - $signed({2'b0, b});
      dc = p - $signed({2'b0, c});
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
   endfunction

   // Stage register.
   logic              st_valid_ff, st_valid_in;
   psu_tag_type       st_tag_ff;
   logic [ADDR_W-1:0] st_addr_ff;

   // Neighbour history; entry k is the byte k+1 places back.
   logic [7:0] left_ff [4];
   logic [7:0] upl_ff  [4];
   logic [7:0] left_in [4];
   logic [7:0] upl_in  [4];

   // Result register.
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_pixel_ff;
   logic       out_row_end_ff;
   logic       out_image_end_ff;
   logic       out_bad_ff;

   logic [1:0] bpp_idx;
   logic [7:0] a, b, c, pred, recon;
   logic [8:0] avg_sum;
   logic       emit;
   logic       out_free;
   logic       st_go;
   logic       is_data;

   always_comb begin
      if (bytes_per_pixel == '0) begin
         bpp_idx = 2'd0;
      end else if (bytes_per_pixel > BPP_W'(4)) begin
         bpp_idx = 2'd3;
      end else begin
         bpp_idx = 2'(bytes_per_pixel - BPP_W'(1));
      end
   end

   // Predictor.
   assign a       = left_ff[bpp_idx];
   assign c       = upl_ff[bpp_idx];
   assign b       = st_tag_ff.first ? 8'd0 : rd_data;
   assign avg_sum = {1'b0, a} + {1'b0, b};

   always_comb begin
      case (st_tag_ff.filt)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = avg_sum[8:1];
         FILT_PAETH: pred = paeth(a, b, c);
         default:    pred = 8'd0;
      endcase
   end

   assign recon = st_tag_ff.data + pred;

   // Stage handshake: a valid filter byte leaves at once, a result needs room.
   assign is_data  = st_tag_ff.kind == TAG_DATA;
   assign emit     = st_tag_ff.kind != TAG_CLEAR;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign st_go    = st_valid_ff && (!emit || out_free);
   assign busy     = st_valid_ff && !st_go;

   assign st_valid_in  = load || (st_valid_ff && !st_go);
   assign out_valid_in = (st_go && emit) || (out_valid_ff && rsp_stall);

   // Write the rebuilt byte back for the next row.
   assign wr_en   = st_go && is_data;
   assign wr_addr = st_addr_ff;
   assign wr_data = recon;

   // History update.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         left_in[k] = left_ff[k];
         upl_in[k]  = upl_ff[k];
      end
      if (st_go) begin
         if (is_data) begin
            left_in[0] = recon;
            upl_in[0]  = b;
            for (int k = 1; k < 4; k++) begin
               left_in[k] = left_ff[k-1];
               upl_in[k]  = upl_ff[k-1];
            end
         end else begin
            for (int k = 0; k < 4; k++) begin
               left_in[k] = 8'd0;
               upl_in[k]  = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            left_ff[k] <= 8'd0;
            upl_ff[k]  <= 8'd0;
         end
      end else begin
         st_valid_ff  <= st_valid_in;
         out_valid_ff <= out_valid_in;
         for (int k = 0; k < 4; k++) begin
            left_ff[k] <= left_in[k];
            upl_ff[k]  <= upl_in[k];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         st_tag_ff  <= tag;
         st_addr_ff <= addr;
      end
      if (st_go && emit) begin
         out_pixel_ff     <= is_data ? recon : 8'd0;
         out_row_end_ff   <= is_data && st_tag_ff.row_end;
         out_image_end_ff <= is_data && st_tag_ff.image_end;
         out_bad_ff       <= !is_data;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_byte = out_pixel_ff;
   assign rsp_row_end    = out_row_end_ff;
   assign rsp_image_end  = out_image_end_ff;
   assign rsp_bad_filter = out_bad_ff;

`ifndef ASSERT_OFF
   // A new item only enters when the stage is empty or leaving.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!st_valid_ff || st_go))
      else $error("stage loaded while occupied");

   // The line store is written only by a data item that moves on.
   a_wr_data: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (st_valid_ff && is_data && (!out_valid_ff || !rsp_stall)))
      else $error("line store written without a leaving data item");

   // The stage is blocked only behind a held result that is stalled.
   a_block: assert property (@(posedge clock) disable iff (reset)
      busy |-> (out_valid_ff && rsp_stall))
      else $error("stage blocked without a stalled result");
`endif

endmodule
`default_nettype wire

FILE: rtl/png_scanline_unfilter_unit.sv
// Top level of the PNG scanline unfilter unit: registers, framing, line store and reconstruction.
//
//  Channel | Direction | Handshake         | Payload
//  req     | in        | req_valid/stall   | req_data_byte
//  rsp     | out       | rsp_valid/stall   | rsp_pixel_byte, row_end, image_end, bad_filter
//  csr     | in        | csr_wr_en         | csr_index, csr_wdata
//
// One item is accepted every cycle unless req_stall is high; a result passes through the
// stage register and the result register. The byte above is read from the line store at
// acceptance and used in the reconstruction stage, where the left-neighbour loop closes.
// Reset is synchronous; the line store is not cleared, the first row of each image
// reads zero above. A stalled result holds back one more item in the reconstruction
// stage, after which req_stall rises.
`default_nettype none
module png_scanline_unfilter_unit #(
   parameter int MAX_ROW_BYTES = psu_pkg::DEF_MAX_ROW_BYTES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [7:0]                     req_data_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [7:0]                     rsp_pixel_byte,
   output logic                                rsp_row_end,
   output logic                                rsp_image_end,
   output logic                                rsp_bad_filter,
   input  wire logic                           csr_wr_en,
   input  wire logic [psu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [psu_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import psu_pkg::*;

   localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

   logic [RB_W-1:0]  row_bytes_ff;
   logic [BPP_W-1:0] bpp_ff;
   logic [RC_W-1:0]  row_count_ff;

   logic              accept;
   logic              tag_valid;
   psu_tag_type       tag;
   logic              rd_en;
   logic [ADDR_W-1:0] col_addr;
   logic [7:0]        rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= RB_W'(1);
         bpp_ff       <= BPP_W'(1);
         row_count_ff <= RC_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROW_BYTES: row_bytes_ff <= csr_wdata[RB_W-1:0];
            CSR_BPP:       bpp_ff       <= csr_wdata[BPP_W-1:0];
            CSR_ROW_COUNT: row_count_ff <= csr_wdata[RC_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   psu_ctrl #(
      .MAX_ROW_BYTES(MAX_ROW_BYTES),
      .COL_W        (ADDR_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .data_byte(req_data_byte),
      .row_bytes(row_bytes_ff),
      .row_count(row_count_ff),
      .tag_valid(tag_valid),
      .tag      (tag),
      .rd_en    (rd_en),
      .col_addr (col_addr)
   );

   psu_line_store #(
      .DEPTH (MAX_ROW_BYTES),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(col_addr),
      .rd_data(rd_data)
   );

   psu_recon #(
      .ADDR_W(ADDR_W)
   ) u_recon (
      .clock          (clock),
      .reset          (reset),
      .load           (accept && tag_valid),
      .tag            (tag),
      .addr           (col_addr),
      .rd_data        (rd_data),
      .bytes_per_pixel(bpp_ff),
      .rsp_stall      (rsp_stall),
      .busy           (busy),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_row_end    (rsp_row_end),
      .rsp_image_end  (rsp_image_end),
      .rsp_bad_filter (rsp_bad_filter)
   );

`ifndef ASSERT_OFF
   // An error result carries no pixel and no framing marks.
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_filter) |-> (rsp_pixel_byte == 8'd0 && !rsp_row_end
                                         && !rsp_image_end))
      else $error("error result with data");

   // The last byte of an image is also the last byte of its row.
   a_image_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_image_end) |-> rsp_row_end)
      else $error("image end without row end");

   // No result is pending straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire
